>>> design/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg: shared types, constants and a function for the packet framer
// Holds the byte-sequencer phase encoding, the beat and status structs
// passed between modules, and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package pfc_pkg;

  // CRC-16 polynomial and top bit for the MSB-first shift.
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  // Control byte sent as the third byte of every header.
  localparam logic [7:0] CTRL_BYTE = 8'h01;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 1'b1;

  // Reset values of the sync bytes.
  localparam logic [7:0] HEADER_FIRST_RST  = 8'h55;
  localparam logic [7:0] HEADER_SECOND_RST = 8'h66;

  // Which byte of the frame the sequencer sends next for the held request.
  typedef enum logic [3:0] {
    PH_START,
    PH_H0,
    PH_H1,
    PH_H2,
    PH_H3,
    PH_H4,
    PH_H5,
    PH_H6,
    PH_H7,
    PH_PAY,
    PH_CRCL,
    PH_CRCH
  } pfc_phase_t;

  // One output byte on its way to the output register.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pfc_beat_t;

  // Sequencer status seen by the top level.
  typedef struct packed {
    logic item_busy;
    logic in_frame;
    logic rem_zero;
  } pfc_status_t;

  // Feeds one byte into the CRC, MSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> design/packet_framer_crc16_top.sv
// ----------------------------------------------------------------------------
// packet_framer_crc16_top: length-prefixed frame encoder with CRC-16 trailer
// Turns requests into the bytes of framed packets on a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one request per payload
//   byte. The first request of a frame also carries command_id,
//   sequence_number and payload_length; a frame with zero length takes one
//   request. The output channel (out_valid / out_stall) carries the frame
//   bytes, with frame_last set on the CRC high byte. A request passes the
//   request register and then the output register before its first byte
//   shows. The sequencer sends one byte per cycle while the receiver takes
//   them; the first request of a frame also sends the header bytes, and the
//   last one the two CRC bytes, during which in_stall is high.
//   The sync bytes are written through cfg_write / cfg_index / cfg_data.
//   Reset returns the sync bytes to 0x55 and 0x66, empties both registers
//   and waits for a frame start. While the receiver stalls, the output byte
//   holds and the sequencer stops, which in turn stalls the input.
// ----------------------------------------------------------------------------
module packet_framer_crc16_top
  import pfc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           command_id,
  input  logic [15:0]          sequence_number,
  input  logic [15:0]          payload_length,
  input  logic [7:0]           payload_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 frame_last,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [7:0]  header_first;
  logic [7:0]  header_second;
  logic        beat_valid;
  logic        beat_ready;
  pfc_beat_t   beat;
  pfc_status_t status;

  // Sync byte registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= HEADER_FIRST_RST;
      header_second <= HEADER_SECOND_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HEADER_FIRST:  header_first  <= cfg_data;
        REG_HEADER_SECOND: header_second <= cfg_data;
        default: ;
      endcase
    end
  end

  pfc_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command_id      (command_id),
    .sequence_number (sequence_number),
    .payload_length  (payload_length),
    .payload_byte    (payload_byte),
    .hdr_first       (header_first),
    .hdr_second      (header_second),
    .beat_valid      (beat_valid),
    .beat            (beat),
    .beat_ready      (beat_ready),
    .status          (status)
  );

  pfc_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_ready (beat_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .frame_last (frame_last)
  );

  // A shown CRC high byte means the frame has already been closed.
  a_last_closes_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> !status.in_frame)
    else $error("frame still open while its last byte is shown");

  // Outside a frame no payload count is left over.
  a_idle_count_clear: assert property (@(posedge clk) disable iff (rst)
    !status.in_frame |-> status.rem_zero)
    else $error("payload count not cleared outside a frame");

  // The input is only held off while a request is being sent.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> status.item_busy)
    else $error("input stalled with no request held");

endmodule

>>> design/pfc_seq.sv
// ----------------------------------------------------------------------------
// pfc_seq: request register and frame byte sequencer
// Holds one input request and sends its bytes one per cycle while the output
// takes them: the header on the first request of a frame, then the payload
// byte (none for an empty frame), then the CRC when the frame ends.
// ----------------------------------------------------------------------------
module pfc_seq
  import pfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  command_id,
  input  logic [15:0] sequence_number,
  input  logic [15:0] payload_length,
  input  logic [7:0]  payload_byte,
  input  logic [7:0]  hdr_first,
  input  logic [7:0]  hdr_second,
  output logic        beat_valid,
  output pfc_beat_t   beat,
  input  logic        beat_ready,
  output pfc_status_t status
);

  // Held request.
  logic        item_valid;
  logic [7:0]  item_cmd;
  logic [15:0] item_seq;
  logic [15:0] item_len;
  logic [7:0]  item_pb;

  // Frame state.
  pfc_phase_t  phase;
  pfc_phase_t  phase_next;
  pfc_phase_t  cur_phase;
  logic [15:0] running_crc;
  logic [15:0] bytes_remaining;
  logic [15:0] rem_dec;
  logic        in_frame;

  logic        emit;
  logic        item_done;
  logic        in_accept;

  // A fresh request starts with the header unless a frame is open.
  assign cur_phase = (phase == PH_START) ? (in_frame ? PH_PAY : PH_H0) : phase;
  assign rem_dec   = bytes_remaining - 16'd1;

  assign emit      = item_valid && beat_ready;
  assign item_done = emit && (phase_next == PH_START);
  assign in_stall  = item_valid && !item_done;
  assign in_accept = in_valid && !in_stall;

  // Next phase after the byte sent in this cycle.
  always_comb begin
    unique case (cur_phase)
      PH_H0:   phase_next = PH_H1;
      PH_H1:   phase_next = PH_H2;
      PH_H2:   phase_next = PH_H3;
      PH_H3:   phase_next = PH_H4;
      PH_H4:   phase_next = PH_H5;
      PH_H5:   phase_next = PH_H6;
      PH_H6:   phase_next = PH_H7;
      PH_H7:   phase_next = (item_len == 16'd0) ? PH_CRCL : PH_PAY;
      PH_PAY:  phase_next = (rem_dec == 16'd0) ? PH_CRCL : PH_START;
      PH_CRCL: phase_next = PH_CRCH;
      PH_CRCH: phase_next = PH_START;
      default: phase_next = PH_START;
    endcase
  end

  // Byte sent in the current phase.
  always_comb begin
    beat.last = 1'b0;
    unique case (cur_phase)
      PH_H0:   beat.data = hdr_first;
      PH_H1:   beat.data = hdr_second;
      PH_H2:   beat.data = CTRL_BYTE;
      PH_H3:   beat.data = item_len[7:0];
      PH_H4:   beat.data = item_len[15:8];
      PH_H5:   beat.data = item_seq[7:0];
      PH_H6:   beat.data = item_seq[15:8];
      PH_H7:   beat.data = item_cmd;
      PH_PAY:  beat.data = item_pb;
      PH_CRCL: beat.data = running_crc[7:0];
      PH_CRCH: begin
        beat.data = running_crc[15:8];
        beat.last = 1'b1;
      end
      default: beat.data = 8'h00;
    endcase
  end

  assign beat_valid = item_valid;

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_accept) begin
      item_valid <= 1'b1;
    end else if (item_done) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_cmd <= command_id;
      item_seq <= sequence_number;
      item_len <= payload_length;
      item_pb  <= payload_byte;
    end
  end

  // Phase moves per byte; CRC over header and payload; count per payload byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_START;
      running_crc     <= 16'h0000;
      bytes_remaining <= 16'd0;
      in_frame        <= 1'b0;
    end else begin
      if (in_accept) begin
        phase <= PH_START;
      end else if (emit) begin
        phase <= phase_next;
      end
      if (emit) begin
        case (cur_phase)
          PH_H0: begin
            running_crc <= crc_feed(16'h0000, beat.data);
          end
          PH_H7: begin
            running_crc <= crc_feed(running_crc, beat.data);
            if (item_len != 16'd0) begin
              bytes_remaining <= item_len;
              in_frame        <= 1'b1;
            end
          end
          PH_PAY: begin
            running_crc     <= crc_feed(running_crc, beat.data);
            bytes_remaining <= rem_dec;
          end
          PH_CRCL: begin
            running_crc <= running_crc;
          end
          PH_CRCH: begin
            running_crc     <= 16'h0000;
            bytes_remaining <= 16'd0;
            in_frame        <= 1'b0;
          end
          default: begin
            running_crc <= crc_feed(running_crc, beat.data);
          end
        endcase
      end
    end
  end

  assign status.item_busy = item_valid;
  assign status.in_frame  = in_frame;
  assign status.rem_zero  = (bytes_remaining == 16'd0);

endmodule

>>> design/pfc_out_stage.sv
// ----------------------------------------------------------------------------
// pfc_out_stage: output register of the framer
// Holds one byte for the receiver and takes the next byte in the cycle the
// held one is taken, so the sequencer keeps running while output is free.
// ----------------------------------------------------------------------------
module pfc_out_stage
  import pfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       beat_valid,
  input  pfc_beat_t  beat,
  output logic       beat_ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       frame_last
);

  assign beat_ready = !out_valid || !out_stall;

  // Valid flag of the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (beat_valid && beat_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output byte and end-of-frame mark.
  always_ff @(posedge clk) begin
    if (beat_valid && beat_ready) begin
      out_byte   <= beat.data;
      frame_last <= beat.last;
    end
  end

endmodule

>>> tb/packet_framer_crc16_top_test.sv
// ----------------------------------------------------------------------------
// packet_framer_crc16_top_test: self-checking bench for the frame encoder
// Sends frames of random length and content through the request channel,
// rebuilds every expected byte (header, payload, CRC-16 trailer) in a local
// model and checks the byte stream under random idling and backpressure.
// ----------------------------------------------------------------------------
module packet_framer_crc16_top_test;
  import pfc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 170;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned LONGEST_BODY = 7;

  logic                 clk             = 1'b0;
  logic                 rst             = 1'b1;
  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  logic [7:0]           command_id      = 8'h00;
  logic [15:0]          sequence_number = 16'h0000;
  logic [15:0]          payload_length  = 16'h0000;
  logic [7:0]           payload_byte    = 8'h00;
  logic                 out_valid;
  logic                 out_stall       = 1'b0;
  logic [7:0]           out_byte;
  logic                 frame_last;
  logic                 cfg_write       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = REG_HEADER_FIRST;
  logic [7:0]           cfg_data        = 8'h00;

  // Local copy of the framer state and sync bytes.
  logic [7:0]  sync_first  = HEADER_FIRST_RST;
  logic [7:0]  sync_second = HEADER_SECOND_RST;
  logic [15:0] frame_crc   = 16'h0000;
  logic [15:0] bytes_left  = 16'h0000;
  logic        frame_open  = 1'b0;

  // Frame bytes still to come out of the block, oldest first.
  pfc_beat_t expected_bytes[$];
  pfc_beat_t rx_want;

  int unsigned mismatches        = 0;
  int unsigned quiet_cycles      = 0;
  int unsigned stall_run         = 0;
  int unsigned rx_gap            = 0;
  bit          tx_idle_on        = 1'b1;
  bit          rx_idle_on        = 1'b1;
  bit          long_hold_pending = 1'b0;

  packet_framer_crc16_top uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command_id      (command_id),
    .sequence_number (sequence_number),
    .payload_length  (payload_length),
    .payload_byte    (payload_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .frame_last      (frame_last),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Payload length of a random frame: mostly short, some empty.
  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      return 0;
    end else if (r < 70) begin
      return $urandom_range(1, 6);
    end else if (r < 95) begin
      return $urandom_range(7, 20);
    end
    return $urandom_range(21, 64);
  endfunction

  // CRC-16 update, one bit at a time from the top bit of the byte down.
  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] value);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ value[i];
      c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  // Queues one frame byte; every byte but the CRC high byte enters the CRC.
  task automatic push_frame_byte(input logic [7:0] value, input logic last);
    expected_bytes.push_back('{data: value, last: last});
    if (!last) begin
      frame_crc = crc_next(frame_crc, value);
    end
  endtask

  // Queues the CRC trailer and closes the frame.
  task automatic push_trailer();
    logic [15:0] c;
    c = frame_crc;
    push_frame_byte(c[7:0], 1'b0);
    push_frame_byte(c[15:8], 1'b1);
    frame_crc = 16'h0000;
    bytes_left = 16'h0000;
    frame_open = 1'b0;
  endtask

  // Works out the bytes that one accepted request produces.
  task automatic predict_frame_bytes(input logic [7:0] cmd, input logic [15:0] seq,
                                     input logic [15:0] len, input logic [7:0] pb);
    bit done;
    done = 1'b0;
    if (!frame_open) begin
      frame_crc = 16'h0000;
      push_frame_byte(sync_first, 1'b0);
      push_frame_byte(sync_second, 1'b0);
      push_frame_byte(CTRL_BYTE, 1'b0);
      push_frame_byte(len[7:0], 1'b0);
      push_frame_byte(len[15:8], 1'b0);
      push_frame_byte(seq[7:0], 1'b0);
      push_frame_byte(seq[15:8], 1'b0);
      push_frame_byte(cmd, 1'b0);
      if (len == 16'h0000) begin
        push_trailer();
        done = 1'b1;
      end else begin
        bytes_left = len;
        frame_open = 1'b1;
      end
    end
    if (!done) begin
      push_frame_byte(pb, 1'b0);
      bytes_left = bytes_left - 16'd1;
      if (bytes_left == 16'h0000) begin
        push_trailer();
      end
    end
  endtask

  // Offers one request after an optional gap and waits until it is taken.
  // The valid stays high on return so that the next request can follow at once.
  task automatic send_request(input logic [7:0] cmd, input logic [15:0] seq,
                              input logic [15:0] len, input logic [7:0] pb);
    int unsigned gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command_id      <= cmd;
    sequence_number <= seq;
    payload_length  <= len;
    payload_byte    <= pb;
    in_valid        <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_frame_bytes(cmd, seq, len, pb);
  endtask

  // Sends the rest of an open frame with random bytes and ignored header fields.
  task automatic send_frame_body(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      send_request(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    end
  endtask

  // Stops offering requests until every expected byte has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes one sync byte register; the model follows at once.
  task automatic write_sync(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_HEADER_FIRST) begin
      sync_first = value;
    end else if (idx == REG_HEADER_SECOND) begin
      sync_second = value;
    end
    @(posedge clk);
  endtask

  // Empty frames: header and trailer from one request, payload byte ignored.
  task automatic test_zero_length();
    send_request(8'hFF, 16'hFFFF, 16'h0000, 8'hFF);
    send_request(8'h00, 16'h0000, 16'h0000, 8'h5A);
    wait_drained();
  endtask

  // One-, two- and three-byte frames, with header fields on later requests ignored.
  task automatic test_short_frames();
    send_request(8'h00, 16'h0000, 16'h0001, 8'h00);
    send_request(8'hA5, 16'h8001, 16'h0002, 8'hFF);
    send_request(8'hFF, 16'hFFFF, 16'hFFFF, 8'h00);
    send_request(8'h3C, 16'h1234, 16'h0003, 8'h80);
    send_request(8'h00, 16'h0000, 16'h0000, 8'h01);
    send_request(8'hFF, 16'hFFFF, 16'h0001, 8'h7F);
    wait_drained();
  endtask

  // Sync bytes at their extremes, and a change in the middle of a frame
  // that only shows up from the next header on.
  task automatic test_sync_registers();
    write_sync(REG_HEADER_FIRST, 8'h00);
    write_sync(REG_HEADER_SECOND, 8'hFF);
    send_request(8'h12, 16'h3456, 16'h0000, 8'h00);
    send_request(8'h9A, 16'hBCDE, 16'h0001, 8'hF0);
    wait_drained();
    write_sync(REG_HEADER_FIRST, 8'hFF);
    write_sync(REG_HEADER_SECOND, 8'h00);
    send_request(8'h01, 16'h0100, 16'h0000, 8'h00);
    send_request(8'h42, 16'h4242, 16'h0003, 8'h11);
    wait_drained();
    write_sync(REG_HEADER_FIRST, 8'hC3);
    write_sync(REG_HEADER_SECOND, 8'h3C);
    send_request(8'h00, 16'h0000, 16'h0000, 8'h22);
    send_request(8'h00, 16'h0000, 16'h0000, 8'h33);
    send_request(8'h77, 16'h0707, 16'h0000, 8'h00);
    wait_drained();
    write_sync(REG_HEADER_FIRST, HEADER_FIRST_RST);
    write_sync(REG_HEADER_SECOND, HEADER_SECOND_RST);
  endtask

  // Random frames with occasional sync byte changes and sender pauses.
  task automatic test_random_frames();
    int unsigned count;
    int unsigned len;
    count = 0;
    while (count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        wait_drained();
        write_sync($urandom_range(0, 1) ? REG_HEADER_SECOND : REG_HEADER_FIRST,
                   8'($urandom_range(0, 255)));
      end else if ($urandom_range(0, 14) == 0) begin
        wait_drained();
      end
      tx_idle_on = ($urandom_range(0, 5) != 0);
      rx_idle_on = ($urandom_range(0, 5) != 0);
      len = pick_length();
      send_request(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), 16'(len),
                   8'($urandom_range(0, 255)));
      count++;
      if (len > 1) begin
        send_frame_body(len - 1);
        count += len - 1;
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while requests keep coming,
  // so the block fills up and stalls its input.
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    long_hold_pending = 1'b1;
    send_request(8'hE7, 16'h2468, 16'd48, 8'hAA);
    send_frame_body(47);
    wait_drained();
    tx_idle_on = 1'b1;
  endtask

  // The largest length field: header and the first payload bytes of a frame
  // that stays open to the end of the run.
  task automatic test_longest_frame();
    write_sync(REG_HEADER_FIRST, 8'($urandom_range(0, 255)));
    write_sync(REG_HEADER_SECOND, 8'($urandom_range(0, 255)));
    send_request(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), 16'hFFFF,
                 8'($urandom_range(0, 255)));
    send_frame_body(LONGEST_BODY);
    wait_drained();
  endtask

  // Checks each byte taken from the block.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected byte, expected none, actual %02h last %0b",
                 $time, out_byte, frame_last);
      end else begin
        rx_want = expected_bytes.pop_front();
        if (out_byte !== rx_want.data || frame_last !== rx_want.last) begin
          mismatches++;
          $display("%0t: byte mismatch, expected %02h last %0b, actual %02h last %0b",
                   $time, rx_want.data, rx_want.last, out_byte, frame_last);
        end
      end
    end
  end

  // Receiver side: drives the output stall, with random gaps and one long hold.
  always @(posedge clk) begin
    if (long_hold_pending) begin
      stall_run = LONG_HOLD;
      long_hold_pending = 1'b0;
    end
    if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else if (!rx_idle_on) begin
      out_stall <= 1'b0;
    end else begin
      rx_gap = pick_gap();
      if (rx_gap > 0) begin
        out_stall <= 1'b1;
        stall_run = rx_gap - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Ends the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_zero_length();
    test_short_frames();
    test_sync_registers();
    test_random_frames();
    test_backpressure();
    test_longest_frame();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
design/pfc_pkg.sv
design/pfc_seq.sv
design/pfc_out_stage.sv
design/packet_framer_crc16_top.sv
tb/packet_framer_crc16_top_test.sv
